// ===== rtl/core/cfs_pkg.sv =====
package cfs_pkg;

  localparam int unsigned FIELD_MAX   = 64;
  localparam int unsigned LEN_W       = $clog2(FIELD_MAX + 1);
  localparam int unsigned IDX_W       = $clog2(FIELD_MAX);
  localparam int unsigned STORE_AW    = IDX_W + 1;
  localparam int unsigned STORE_DEPTH = 1 << STORE_AW;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [7:0] SPACE_BYTE      = 8'h20;
  localparam logic [7:0] QUOTE_BYTE      = 8'h22;
  localparam logic [7:0] DELIMITER_RESET = 8'd44;
  localparam logic [7:0] ESCAPE_RESET    = 8'd92;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DELIMITER,
    CFG_ESCAPE
  } cfg_reg_e;

  typedef enum logic [1:0] {
    STATUS_OK,
    STATUS_UNMATCHED,
    STATUS_TOO_LONG
  } status_e;

  typedef enum logic {
    F_ACCEPT,
    F_FLUSH
  } front_state_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_RD,
    B_DATA,
    B_END
  } back_state_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       string_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       field_empty;
    logic       field_done;
    logic       string_done;
    logic [1:0] field_status;
  } out_item_t;

  typedef struct packed {
    logic       kill;
    logic [7:0] data;
  } entry_t;

  typedef struct packed {
    logic                en;
    logic [STORE_AW-1:0] addr;
    entry_t              entry;
  } wr_t;

  typedef struct packed {
    logic             bank;
    logic [LEN_W-1:0] len;
    status_e          status;
    logic             quoted;
    logic             str_end;
  } desc_t;

endpackage

// ===== rtl/core/cfs_in_if.sv =====
interface cfs_in_if;
  logic               valid;
  logic               ready;
  cfs_pkg::in_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/cfs_out_if.sv =====
interface cfs_out_if;
  logic               valid;
  logic               ready;
  cfs_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/cfs_field_store.sv =====
module cfs_field_store (
  input  logic                          clk_i,
  input  cfs_pkg::wr_t                  wr_i,
  input  logic                          rd_en_i,
  input  logic [cfs_pkg::STORE_AW-1:0]  rd_addr_i,
  output cfs_pkg::entry_t               rd_entry_o
);

  cfs_pkg::entry_t mem_q [cfs_pkg::STORE_DEPTH];
  cfs_pkg::entry_t rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.entry;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_entry_o = rd_q;

endmodule

// ===== rtl/core/cfs_desc_queue.sv =====
module cfs_desc_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  cfs_pkg::desc_t  desc_i,
  input  logic            pop_i,
  output cfs_pkg::desc_t  head_o,
  output logic            valid_o,
  output logic            full_o
);

  cfs_pkg::desc_t slot_q [2];
  logic           wptr_q, wptr_d;
  logic           rptr_q, rptr_d;
  logic [1:0]     count_q, count_d;

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (push_i) begin
      wptr_d = ~wptr_q;
    end
    if (pop_i) begin
      rptr_d = ~rptr_q;
    end
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + 2'd1;
      2'b01:   count_d = count_q - 2'd1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= desc_i;
    end
  end

  assign head_o  = slot_q[rptr_q];
  assign valid_o = (count_q != 2'd0);
  assign full_o  = (count_q == 2'd2);

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("descriptor pushed into full queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o) else $error("descriptor popped from empty queue");

endmodule

// ===== rtl/core/cfs_front.sv =====
module cfs_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [cfs_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [cfs_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  cfs_in_if.sink                          in_if,
  input  logic                            q_full_i,
  output logic                            push_o,
  output cfs_pkg::desc_t                  desc_o,
  output cfs_pkg::wr_t                    wr_o
);

  localparam int unsigned LW = cfs_pkg::LEN_W;

  cfs_pkg::front_state_e state_q, state_d;
  logic [7:0]    delim_q, esc_q;
  logic [LW-1:0] len_q, len_d;
  logic [LW-1:0] etrim_q, etrim_d;
  logic          fq_q, fq_d;
  logic          lq_q, lq_d;
  logic          ovf_q, ovf_d;
  logic          pwe_q, pwe_d;
  logic          started_q, started_d;
  logic [7:0]    held_q, held_d;
  logic          held_v_q, held_v_d;
  logic          str_end_q, str_end_d;
  logic          bank_q, bank_d;

  logic [LW-1:0] len_m1;
  logic          trim_one, has_bytes;

  assign len_m1    = len_q - LW'(1);
  assign trim_one  = (etrim_q == LW'(1));
  assign has_bytes = (etrim_q != '0);

  always_comb begin
    logic [7:0] b;
    logic       last;
    b          = in_if.data.in_byte;
    last       = in_if.data.string_last;
    state_d    = state_q;
    len_d      = len_q;
    etrim_d    = etrim_q;
    fq_d       = fq_q;
    lq_d       = lq_q;
    ovf_d      = ovf_q;
    pwe_d      = pwe_q;
    started_d  = started_q;
    held_d     = held_q;
    held_v_d   = held_v_q;
    str_end_d  = str_end_q;
    bank_d     = bank_q;
    in_if.ready = 1'b0;
    push_o     = 1'b0;
    wr_o       = '0;
    wr_o.addr  = {bank_q, len_m1[cfs_pkg::IDX_W-1:0]};
    wr_o.entry.data = held_q;

    desc_o.bank    = bank_q;
    desc_o.len     = etrim_q;
    desc_o.str_end = str_end_q;
    desc_o.quoted  = !ovf_q && has_bytes && fq_q && lq_q && !trim_one;
    if (ovf_q) begin
      desc_o.status = cfs_pkg::STATUS_TOO_LONG;
    end else if (has_bytes && (fq_q || lq_q) && (trim_one || !fq_q || !lq_q)) begin
      desc_o.status = cfs_pkg::STATUS_UNMATCHED;
    end else begin
      desc_o.status = cfs_pkg::STATUS_OK;
    end

    case (state_q)
      cfs_pkg::F_ACCEPT: begin
        in_if.ready = !q_full_i;
        if (in_if.valid && !q_full_i) begin
          if (b == delim_q && !started_q) begin
            // drop: empty raw field
          end else if (b == delim_q && !pwe_q) begin
            str_end_d = last;
            state_d   = cfs_pkg::F_FLUSH;
          end else begin
            started_d = 1'b1;
            pwe_d     = (b == esc_q);
            if (!(len_q == '0 && b == cfs_pkg::SPACE_BYTE)) begin
              if (len_q < LW'(cfs_pkg::FIELD_MAX)) begin
                wr_o.en         = held_v_q;
                wr_o.entry.kill = (b == delim_q) && (held_q == esc_q);
                held_d   = b;
                held_v_d = 1'b1;
                len_d    = len_q + LW'(1);
                if (b != cfs_pkg::SPACE_BYTE) begin
                  etrim_d = len_q + LW'(1);
                  lq_d    = (b == cfs_pkg::QUOTE_BYTE);
                end
                if (len_q == '0) begin
                  fq_d = (b == cfs_pkg::QUOTE_BYTE);
                end
              end else begin
                ovf_d = 1'b1;
              end
            end
            if (last) begin
              str_end_d = 1'b1;
              state_d   = cfs_pkg::F_FLUSH;
            end
          end
        end
      end
      cfs_pkg::F_FLUSH: begin
        wr_o.en   = held_v_q;
        push_o    = 1'b1;
        bank_d    = ~bank_q;
        len_d     = '0;
        etrim_d   = '0;
        fq_d      = 1'b0;
        lq_d      = 1'b0;
        ovf_d     = 1'b0;
        pwe_d     = 1'b0;
        started_d = 1'b0;
        held_v_d  = 1'b0;
        str_end_d = 1'b0;
        state_d   = cfs_pkg::F_ACCEPT;
      end
      default: state_d = cfs_pkg::F_ACCEPT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= cfs_pkg::F_ACCEPT;
      delim_q   <= cfs_pkg::DELIMITER_RESET;
      esc_q     <= cfs_pkg::ESCAPE_RESET;
      len_q     <= '0;
      etrim_q   <= '0;
      fq_q      <= 1'b0;
      lq_q      <= 1'b0;
      ovf_q     <= 1'b0;
      pwe_q     <= 1'b0;
      started_q <= 1'b0;
      held_v_q  <= 1'b0;
      str_end_q <= 1'b0;
      bank_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      len_q     <= len_d;
      etrim_q   <= etrim_d;
      fq_q      <= fq_d;
      lq_q      <= lq_d;
      ovf_q     <= ovf_d;
      pwe_q     <= pwe_d;
      started_q <= started_d;
      held_v_q  <= held_v_d;
      str_end_q <= str_end_d;
      bank_q    <= bank_d;
      if (cfg_we_i && cfg_idx_i == cfs_pkg::CFG_DELIMITER) begin
        delim_q <= cfg_data_i[7:0];
      end
      if (cfg_we_i && cfg_idx_i == cfs_pkg::CFG_ESCAPE) begin
        esc_q <= cfg_data_i[7:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    held_q <= held_d;
  end

endmodule

// ===== rtl/core/cfs_back.sv =====
module cfs_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cfs_pkg::desc_t                desc_i,
  input  logic                          desc_valid_i,
  output logic                          pop_o,
  output logic                          rd_en_o,
  output logic [cfs_pkg::STORE_AW-1:0]  rd_addr_o,
  input  cfs_pkg::entry_t               rd_entry_i,
  cfs_out_if.source                     out_if
);

  localparam int unsigned LW = cfs_pkg::LEN_W;

  cfs_pkg::back_state_e state_q, state_d;
  logic [LW-1:0]       idx_q, idx_d;
  logic                pend_v_q, pend_v_d;
  logic [7:0]          pend_q, pend_d;
  logic                out_valid_q, out_valid_d;
  cfs_pkg::out_item_t  out_q, out_d;

  logic [LW-1:0] first, stop, idx_nxt;
  logic          slot, keep;

  assign first   = desc_i.quoted ? LW'(1) : '0;
  assign stop    = desc_i.quoted ? (desc_i.len - LW'(1)) : desc_i.len;
  assign idx_nxt = idx_q + LW'(1);
  assign slot    = !out_valid_q || out_if.ready;
  assign keep    = !(desc_i.quoted && rd_entry_i.kill);

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    pend_v_d    = pend_v_q;
    pend_d      = pend_q;
    out_valid_d = out_valid_q && !out_if.ready;
    out_d       = out_q;
    pop_o       = 1'b0;
    rd_en_o     = 1'b0;
    rd_addr_o   = {desc_i.bank, idx_q[cfs_pkg::IDX_W-1:0]};

    case (state_q)
      cfs_pkg::B_IDLE: begin
        if (desc_valid_i) begin
          idx_d    = first;
          pend_v_d = 1'b0;
          state_d  = (first < stop) ? cfs_pkg::B_RD : cfs_pkg::B_END;
        end
      end
      cfs_pkg::B_RD: begin
        rd_en_o = 1'b1;
        state_d = cfs_pkg::B_DATA;
      end
      cfs_pkg::B_DATA: begin
        if (!(keep && pend_v_q) || slot) begin
          if (keep && pend_v_q) begin
            out_valid_d        = 1'b1;
            out_d.out_byte     = pend_q;
            out_d.field_empty  = 1'b0;
            out_d.field_done   = 1'b0;
            out_d.string_done  = desc_i.str_end;
            out_d.field_status = desc_i.status;
          end
          if (keep) begin
            pend_d   = rd_entry_i.data;
            pend_v_d = 1'b1;
          end
          idx_d   = idx_nxt;
          state_d = (idx_nxt < stop) ? cfs_pkg::B_RD : cfs_pkg::B_END;
        end
      end
      cfs_pkg::B_END: begin
        if (slot) begin
          out_valid_d        = 1'b1;
          out_d.out_byte     = pend_v_q ? pend_q : 8'd0;
          out_d.field_empty  = !pend_v_q;
          out_d.field_done   = 1'b1;
          out_d.string_done  = desc_i.str_end;
          out_d.field_status = desc_i.status;
          pop_o              = 1'b1;
          state_d            = cfs_pkg::B_IDLE;
        end
      end
      default: state_d = cfs_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cfs_pkg::B_IDLE;
      idx_q       <= '0;
      pend_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      pend_v_q    <= pend_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  assign out_if.valid = out_valid_q;
  assign out_if.data  = out_q;

  a_busy_has_desc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != cfs_pkg::B_IDLE) |-> desc_valid_i)
    else $error("back end busy without a queued field");

endmodule

// ===== rtl/core/clean_field_splitter_core.sv =====
// Channel   Dir  Payload                                                Handshake
// in_i      in   in_byte, string_last                                   valid/ready
// out_o     out  out_byte, field_empty, field_done, string_done,
//                field_status                                           valid/ready
// cfg_*     in   cfg_idx_i, cfg_data_i                                  cfg_we_i
//
// Front end takes one byte per cycle while the queue is not full; it closes each
// field in F_FLUSH, taking no byte. Back end reads each stored byte in B_RD (address),
// then B_DATA (registered read); B_IDLE starts a field and B_END sends its final item.
// Two field banks in the store; the front stalls while both hold unsent fields.
// No clearing pass after reset; the store is read only where it was written.
// A stalled output holds its item; the front accepts bytes until both banks are in use.
module clean_field_splitter_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [cfs_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [cfs_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  cfs_in_if.sink                          in_i,
  cfs_out_if.source                       out_o
);

  logic                          push, pop, q_valid, q_full, rd_en;
  cfs_pkg::desc_t                desc_in, desc_head;
  cfs_pkg::wr_t                  wr;
  logic [cfs_pkg::STORE_AW-1:0]  rd_addr;
  cfs_pkg::entry_t               rd_entry;

  cfs_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_if      (in_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .desc_o     (desc_in),
    .wr_o       (wr)
  );

  cfs_field_store u_store (
    .clk_i      (clk_i),
    .wr_i       (wr),
    .rd_en_i    (rd_en),
    .rd_addr_i  (rd_addr),
    .rd_entry_o (rd_entry)
  );

  cfs_desc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .desc_i  (desc_in),
    .pop_i   (pop),
    .head_o  (desc_head),
    .valid_o (q_valid),
    .full_o  (q_full)
  );

  cfs_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .desc_i       (desc_head),
    .desc_valid_i (q_valid),
    .pop_o        (pop),
    .rd_en_o      (rd_en),
    .rd_addr_o    (rd_addr),
    .rd_entry_i   (rd_entry),
    .out_if       (out_o)
  );

endmodule

// ===== tb/clean_field_splitter_core_tb.sv =====
`timescale 1ns / 1ps

module clean_field_splitter_core_tb;

  localparam int QUIET_LIMIT = 2000;
  localparam int SETTLE = 20;
  localparam int LONG_HOLD = 300;

  logic clk_i;
  logic rst_ni;
  logic cfg_we;
  logic [cfs_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [cfs_pkg::CFG_DATA_W-1:0] cfg_data;

  cfs_in_if in_ch();
  cfs_out_if out_ch();

  clean_field_splitter_core dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we),
    .cfg_idx_i(cfg_idx),
    .cfg_data_i(cfg_data),
    .in_i(in_ch),
    .out_o(out_ch)
  );

  logic [7:0] split_delim;
  logic [7:0] escape_val;
  logic [7:0] fld_store[cfs_pkg::FIELD_MAX];
  int fld_len;
  bit after_escape;
  bit fld_overflow;
  bit fld_started;

  cfs_pkg::out_item_t cleaned_q[$];
  cfs_pkg::out_item_t want;
  int mismatches;
  int quiet_cycles;
  int gap_pct;
  int stall_pct;
  int hold_left;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void close_field(bit str_end);
    int last_i;
    int i;
    cfs_pkg::status_e st;
    bit quoted;
    cfs_pkg::out_item_t r;
    cfs_pkg::out_item_t run[$];
    last_i = fld_len;
    while (last_i > 0 && fld_store[last_i-1] == cfs_pkg::SPACE_BYTE) last_i--;
    st = cfs_pkg::STATUS_OK;
    quoted = 1'b0;
    if (fld_overflow) begin
      st = cfs_pkg::STATUS_TOO_LONG;
    end else if (last_i > 0 && (fld_store[0] == cfs_pkg::QUOTE_BYTE ||
                                fld_store[last_i-1] == cfs_pkg::QUOTE_BYTE)) begin
      if (last_i == 1 || fld_store[0] != cfs_pkg::QUOTE_BYTE ||
          fld_store[last_i-1] != cfs_pkg::QUOTE_BYTE) begin
        st = cfs_pkg::STATUS_UNMATCHED;
      end else begin
        quoted = 1'b1;
      end
    end
    r = '0;
    r.field_status = st;
    if (quoted) begin
      for (i = 1; i + 1 < last_i; i++) begin
        if (!(fld_store[i] == escape_val && fld_store[i+1] == split_delim)) begin
          r.out_byte = fld_store[i];
          run = {run, r};
        end
      end
    end else begin
      for (i = 0; i < last_i; i++) begin
        r.out_byte = fld_store[i];
        run = {run, r};
      end
    end
    if (run.size() == 0) begin
      r.out_byte = 8'h00;
      r.field_empty = 1'b1;
      run = {run, r};
    end
    run[run.size()-1].field_done = 1'b1;
    foreach (run[k]) begin
      run[k].string_done = str_end;
      cleaned_q = {cleaned_q, run[k]};
    end
    fld_len = 0;
    after_escape = 1'b0;
    fld_overflow = 1'b0;
    fld_started = 1'b0;
  endfunction

  function automatic void take_byte(logic [7:0] b, bit last);
    if (b == split_delim && !fld_started) return;
    if (b == split_delim && !after_escape) begin
      close_field(last);
      return;
    end
    fld_started = 1'b1;
    if (!(fld_len == 0 && b == cfs_pkg::SPACE_BYTE)) begin
      if (fld_len < int'(cfs_pkg::FIELD_MAX)) begin
        fld_store[fld_len] = b;
        fld_len++;
      end else begin
        fld_overflow = 1'b1;
      end
    end
    after_escape = (b == escape_val);
    if (last) close_field(1'b1);
  endfunction

  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(99);
    if (r < 45) return 8'h61 + 8'($urandom_range(25));
    if (r < 57) return cfs_pkg::SPACE_BYTE;
    if (r < 67) return escape_val;
    if (r < 77) return split_delim;
    if (r < 85) return cfs_pkg::QUOTE_BYTE;
    return 8'($urandom_range(255));
  endfunction

  // checker
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (cleaned_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected item: %p", out_ch.data);
      end else begin
        want = cleaned_q.pop_front();
        if (out_ch.data.out_byte !== want.out_byte ||
            out_ch.data.field_empty !== want.field_empty ||
            out_ch.data.field_done !== want.field_done ||
            out_ch.data.string_done !== want.string_done ||
            out_ch.data.field_status !== want.field_status) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("item mismatch: expected byte=%h empty=%b fdone=%b sdone=%b status=%0d",
                     want.out_byte, want.field_empty, want.field_done, want.string_done,
                     want.field_status);
            $display("                 actual byte=%h empty=%b fdone=%b sdone=%b status=%0d",
                     out_ch.data.out_byte, out_ch.data.field_empty, out_ch.data.field_done,
                     out_ch.data.string_done, out_ch.data.field_status);
          end
        end
      end
    end
  end

  // receiver: long hold first, then random stalls
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_ch.ready = 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_ch.ready = ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  task automatic send_byte(logic [7:0] b, bit last);
    while ($urandom_range(99) < gap_pct) @(negedge clk_i);
    in_ch.valid = 1'b1;
    in_ch.data.in_byte = b;
    in_ch.data.string_last = last;
    do @(posedge clk_i); while (!in_ch.ready);
    take_byte(b, last);
    @(negedge clk_i);
    in_ch.valid = 1'b0;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
  endtask

  task automatic send_bytes(logic [7:0] q[$]);
    foreach (q[i]) send_byte(q[i], i == q.size() - 1);
  endtask

  task automatic wait_drained();
    while (cleaned_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic write_reg(cfs_pkg::cfg_reg_e idx, logic [7:0] v);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_data = v;
    @(negedge clk_i);
    cfg_we = 1'b0;
    if (idx == cfs_pkg::CFG_DELIMITER) split_delim = v;
    else escape_val = v;
  endtask

  task automatic set_idling(int mode);
    case (mode)
      0: begin gap_pct = 0; stall_pct = 0; end
      1: begin gap_pct = 53; stall_pct = 0; end
      2: begin gap_pct = 0; stall_pct = 53; end
      default: begin gap_pct = 37; stall_pct = 37; end
    endcase
  endtask

  // quoted, unquoted and unmatched-quote fields with random content, some noise strings; cut to max_n bytes
  task automatic send_random_string(int max_n, output int n);
    logic [7:0] q[$];
    int nfields;
    int kind;
    int len;
    q = {};
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 12)) q = {q, 8'($urandom_range(255))};
    end else begin
      nfields = $urandom_range(1, 4);
      for (int f = 0; f < nfields; f++) begin
        if ($urandom_range(9) != 0) begin
          if ($urandom_range(2) == 0) repeat ($urandom_range(1, 2)) q = {q, cfs_pkg::SPACE_BYTE};
          kind = $urandom_range(9);
          len = ($urandom_range(29) == 0) ? $urandom_range(60, 72) : $urandom_range(0, 10);
          if (kind <= 5) q = {q, cfs_pkg::QUOTE_BYTE};
          repeat (len) q = {q, pick_byte()};
          if (kind <= 4 && $urandom_range(1) == 0) begin
            q = {q, escape_val};
            q = {q, split_delim};
          end
          if (kind <= 4 || kind == 6) q = {q, cfs_pkg::QUOTE_BYTE};
          if ($urandom_range(2) == 0) repeat ($urandom_range(1, 2)) q = {q, cfs_pkg::SPACE_BYTE};
        end
        if (f != nfields - 1 || $urandom_range(4) == 0) q = {q, split_delim};
      end
      if (q.size() == 0) q = {q, pick_byte()};
    end
    if (q.size() > max_n) q = q[0:max_n-1];
    send_bytes(q);
    n = q.size();
  endtask

  task automatic send_random_bytes(int budget);
    int sent;
    int n;
    sent = 0;
    while (sent < budget) begin
      send_random_string(budget - sent, n);
      sent += n;
    end
  endtask

  task automatic test_directed();
    set_idling(0);
    send_text(" ab ,c");
    send_text("  ,,");
    send_text("\"a\\,b\"");
    send_text("\"q,r\",\"");
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    wait_drained();
  endtask

  task automatic test_overflow();
    logic [7:0] q[$];
    set_idling(3);
    q = {cfs_pkg::QUOTE_BYTE};
    repeat (62) q = {q, 8'h41 + 8'($urandom_range(25))};
    repeat (4) q = {q, cfs_pkg::SPACE_BYTE};
    q = {q, cfs_pkg::QUOTE_BYTE};
    q = {q, split_delim};
    send_bytes(q);
    wait_drained();
  endtask

  task automatic test_config_sweep();
    logic [7:0] delims[6];
    logic [7:0] escapes[6];
    delims = '{8'd0, 8'd255, 8'd59, 8'd34, 8'd124, 8'd44};
    escapes = '{8'd255, 8'd0, 8'd59, 8'd92, 8'd94, 8'd92};
    for (int p = 0; p < 6; p++) begin
      write_reg(cfs_pkg::CFG_DELIMITER, delims[p]);
      write_reg(cfs_pkg::CFG_ESCAPE, escapes[p]);
      set_idling(p % 4);
      send_random_bytes(15);
      wait_drained();
    end
  endtask

  task automatic test_backpressure();
    set_idling(0);
    hold_left = LONG_HOLD;
    send_text("a,b,c,d,e,f,g");
    send_random_bytes(17);
    wait_drained();
  endtask

  task automatic test_drain_pause();
    set_idling(3);
    send_random_bytes(8);
    wait_drained();
    send_random_bytes(8);
    wait_drained();
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = cfs_pkg::CFG_DELIMITER;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    split_delim = cfs_pkg::DELIMITER_RESET;
    escape_val = cfs_pkg::ESCAPE_RESET;
    fld_len = 0;
    after_escape = 1'b0;
    fld_overflow = 1'b0;
    fld_started = 1'b0;
    mismatches = 0;
    quiet_cycles = 0;
    gap_pct = 0;
    stall_pct = 0;
    hold_left = 0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    test_overflow();
    test_config_sweep();
    test_backpressure();
    test_drain_pause();

    wait_drained();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
